[design/tba_pkg.sv]
package tba_pkg;

    localparam int COORD_W   = 16;
    localparam int INDEX_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int MAG_W     = CROSS_W - 1;
    localparam int WFRAC     = 16;
    localparam int WEIGHT_W  = 21;
    // quotient bits of |N| * 2^(WFRAC+1) / |D|; one extra bit for rounding
    localparam int Q_W       = WEIGHT_W + 2;
    localparam int REM_W     = MAG_W + Q_W;
    localparam int DIV_LAT   = Q_W + 2;

    typedef logic signed [COORD_W-1:0]  t_coord;
    typedef logic signed [DIFF_W-1:0]   t_diff;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [CROSS_W-1:0]  t_cross;
    typedef logic        [MAG_W-1:0]    t_mag;
    typedef logic        [WEIGHT_W-1:0] t_wmag;
    typedef logic        [INDEX_W-1:0]  t_index;

    localparam t_wmag W_CAP     = t_wmag'(1) << (WEIGHT_W - 1);
    localparam t_wmag W_POS_MAX = W_CAP - t_wmag'(1);

    typedef struct packed {
        logic   valid;
        logic   err;
        t_index idx;
    } t_ctrl;

    typedef struct packed {
        logic   valid;
        logic   err;
        logic   deg;
        logic   in_tri;
        logic   neg0;
        logic   neg1;
        logic   neg2;
        t_index idx;
        t_mag   area;
    } t_info;

    function automatic t_diff sub_ext(input t_coord a, input t_coord b);
        t_diff ea;
        t_diff eb;
        ea = t_diff'(a);
        eb = t_diff'(b);
        return ea - eb;
    endfunction

endpackage

[design/triangle_barycentric_area_core.sv]
// Barycentric weights, area and inside test for one 2D triangle per word.
// A word is taken in every cycle (busy stays low) and its result appears
// on the outputs with o_strobe high after the cross-product, flag and
// division stages; results leave in issue order and the receiver cannot
// stall them. The latency is set by the three parallel division pipelines,
// one quotient bit per stage. element_count is written through the cfg
// channel, always ready; write it only while no words are in flight.
module triangle_barycentric_area_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [tba_pkg::INDEX_W-1:0]     i_element_index,
    input  logic signed [tba_pkg::COORD_W-1:0] i_vert0_x,
    input  logic signed [tba_pkg::COORD_W-1:0] i_vert0_y,
    input  logic signed [tba_pkg::COORD_W-1:0] i_vert1_x,
    input  logic signed [tba_pkg::COORD_W-1:0] i_vert1_y,
    input  logic signed [tba_pkg::COORD_W-1:0] i_vert2_x,
    input  logic signed [tba_pkg::COORD_W-1:0] i_vert2_y,
    input  logic signed [tba_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [tba_pkg::COORD_W-1:0] i_point_y,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tba_pkg::INDEX_W-1:0]     i_cfg_data,
    output logic                            o_strobe,
    output logic [tba_pkg::INDEX_W-1:0]     o_index_tag,
    output logic signed [tba_pkg::WEIGHT_W-1:0] o_weight0,
    output logic signed [tba_pkg::WEIGHT_W-1:0] o_weight1,
    output logic signed [tba_pkg::WEIGHT_W-1:0] o_weight2,
    output logic                            o_inside_res,
    output logic [tba_pkg::MAG_W-1:0]       o_area,
    output logic                            o_degenerate,
    output logic                            o_index_error
);

    tba_pkg::t_index r_count;
    tba_pkg::t_ctrl  r_ctl [0:2];
    tba_pkg::t_ctrl  n_ctl;
    tba_pkg::t_info  r_info;
    tba_pkg::t_info  n_info;
    tba_pkg::t_info  r_dly [0:tba_pkg::DIV_LAT-1];
    tba_pkg::t_mag   r_dmag, r_nmag0, r_nmag1, r_nmag2;
    tba_pkg::t_cross d, n0, n1, n2;
    tba_pkg::t_wmag  mag0, mag1, mag2;
    tba_pkg::t_info  tail;

    logic                       r_strobe, r_inside, r_deg, r_err;
    tba_pkg::t_index            r_tag;
    tba_pkg::t_wmag             r_w0, r_w1, r_w2;
    tba_pkg::t_mag              r_area;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    tba_cross u_cross (
        .i_clk (i_clk),
        .i_x0  (i_vert0_x),
        .i_y0  (i_vert0_y),
        .i_x1  (i_vert1_x),
        .i_y1  (i_vert1_y),
        .i_x2  (i_vert2_x),
        .i_y2  (i_vert2_y),
        .i_px  (i_point_x),
        .i_py  (i_point_y),
        .o_d   (d),
        .o_n0  (n0),
        .o_n1  (n1),
        .o_n2  (n2)
    );

    always_comb begin
        n_ctl.valid = start;
        n_ctl.err   = (i_element_index >= r_count);
        n_ctl.idx   = i_element_index;
    end

    // control words ride alongside the cross-product stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0].valid <= 1'b0;
            r_ctl[1].valid <= 1'b0;
            r_ctl[2].valid <= 1'b0;
        end else begin
            r_ctl[0].valid <= n_ctl.valid;
            r_ctl[1].valid <= r_ctl[0].valid;
            r_ctl[2].valid <= r_ctl[1].valid;
        end
        r_ctl[0].err <= n_ctl.err;
        r_ctl[0].idx <= n_ctl.idx;
        r_ctl[1].err <= r_ctl[0].err;
        r_ctl[1].idx <= r_ctl[0].idx;
        r_ctl[2].err <= r_ctl[1].err;
        r_ctl[2].idx <= r_ctl[1].idx;
    end

    // stage 4: signs, flags and magnitudes
    always_comb begin
        logic zn0, zn1, zn2;
        zn0 = (n0 == '0);
        zn1 = (n1 == '0);
        zn2 = (n2 == '0);
        n_info.valid = r_ctl[2].valid;
        n_info.err   = r_ctl[2].err;
        n_info.idx   = r_ctl[2].idx;
        n_info.deg   = (d == '0);
        n_info.neg0  = n0[tba_pkg::CROSS_W-1] ^ d[tba_pkg::CROSS_W-1];
        n_info.neg1  = n1[tba_pkg::CROSS_W-1] ^ d[tba_pkg::CROSS_W-1];
        n_info.neg2  = n2[tba_pkg::CROSS_W-1] ^ d[tba_pkg::CROSS_W-1];
        if (d[tba_pkg::CROSS_W-1]) begin
            n_info.in_tri = (n0[tba_pkg::CROSS_W-1] || zn0) &&
                            (n1[tba_pkg::CROSS_W-1] || zn1) &&
                            (n2[tba_pkg::CROSS_W-1] || zn2);
            n_info.area   = tba_pkg::MAG_W'(-d);
        end else begin
            n_info.in_tri = !n_info.deg && !n0[tba_pkg::CROSS_W-1] &&
                            !n1[tba_pkg::CROSS_W-1] && !n2[tba_pkg::CROSS_W-1];
            n_info.area   = tba_pkg::MAG_W'(d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_info.valid <= 1'b0;
        end else begin
            r_info.valid <= n_info.valid;
        end
        r_info.err    <= n_info.err;
        r_info.deg    <= n_info.deg;
        r_info.in_tri <= n_info.in_tri;
        r_info.neg0   <= n_info.neg0;
        r_info.neg1   <= n_info.neg1;
        r_info.neg2   <= n_info.neg2;
        r_info.idx    <= n_info.idx;
        r_info.area   <= n_info.area;
        r_dmag  <= n_info.area;
        r_nmag0 <= n0[tba_pkg::CROSS_W-1] ? tba_pkg::MAG_W'(-n0) : tba_pkg::MAG_W'(n0);
        r_nmag1 <= n1[tba_pkg::CROSS_W-1] ? tba_pkg::MAG_W'(-n1) : tba_pkg::MAG_W'(n1);
        r_nmag2 <= n2[tba_pkg::CROSS_W-1] ? tba_pkg::MAG_W'(-n2) : tba_pkg::MAG_W'(n2);
    end

    tba_div_pipe u_div0 (.i_clk(i_clk), .i_num(r_nmag0), .i_den(r_dmag), .o_mag(mag0));
    tba_div_pipe u_div1 (.i_clk(i_clk), .i_num(r_nmag1), .i_den(r_dmag), .o_mag(mag1));
    tba_div_pipe u_div2 (.i_clk(i_clk), .i_num(r_nmag2), .i_den(r_dmag), .o_mag(mag2));

    // flags wait out the divider latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < tba_pkg::DIV_LAT; k++) begin
                r_dly[k] <= '0;
            end
        end else begin
            r_dly[0] <= r_info;
            for (int k = 1; k < tba_pkg::DIV_LAT; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    assign tail = r_dly[tba_pkg::DIV_LAT-1];

    function automatic tba_pkg::t_wmag signed_weight(input tba_pkg::t_wmag mag,
                                                     input logic neg);
        if (neg) begin
            return tba_pkg::t_wmag'(-mag);
        end else if (mag > tba_pkg::W_POS_MAX) begin
            return tba_pkg::W_POS_MAX;
        end
        return mag;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= tail.valid;
        end
        r_tag <= tail.idx;
        r_err <= tail.err;
        if (tail.err || tail.deg) begin
            r_w0     <= '0;
            r_w1     <= '0;
            r_w2     <= '0;
            r_inside <= 1'b0;
            r_area   <= '0;
            r_deg    <= tail.deg && !tail.err;
        end else begin
            r_w0     <= signed_weight(mag0, tail.neg0);
            r_w1     <= signed_weight(mag1, tail.neg1);
            r_w2     <= signed_weight(mag2, tail.neg2);
            r_inside <= tail.in_tri;
            r_area   <= tail.area;
            r_deg    <= 1'b0;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_index_tag   = r_tag;
    assign o_weight0     = r_w0;
    assign o_weight1     = r_w1;
    assign o_weight2     = r_w2;
    assign o_inside_res  = r_inside;
    assign o_area        = r_area;
    assign o_degenerate  = r_deg;
    assign o_index_error = r_err;

    a_err_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_index_error |-> !o_degenerate && o_area == '0 && !o_inside_res
            && o_weight0 == '0 && o_weight1 == '0 && o_weight2 == '0)
        else $error("index error word carries data");

    a_deg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_degenerate |-> o_area == '0 && !o_inside_res
            && o_weight0 == '0 && o_weight1 == '0 && o_weight2 == '0)
        else $error("degenerate word carries data");

    a_inside_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_inside_res |-> !o_weight0[tba_pkg::WEIGHT_W-1]
            && !o_weight1[tba_pkg::WEIGHT_W-1] && !o_weight2[tba_pkg::WEIGHT_W-1])
        else $error("inside word with a negative weight");

    a_area_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_degenerate && !o_index_error |-> o_area != '0)
        else $error("zero area on a non-degenerate word");

endmodule

[design/tba_cross.sv]
module tba_cross (
    input  logic           i_clk,
    input  tba_pkg::t_coord i_x0,
    input  tba_pkg::t_coord i_y0,
    input  tba_pkg::t_coord i_x1,
    input  tba_pkg::t_coord i_y1,
    input  tba_pkg::t_coord i_x2,
    input  tba_pkg::t_coord i_y2,
    input  tba_pkg::t_coord i_px,
    input  tba_pkg::t_coord i_py,
    output tba_pkg::t_cross o_d,
    output tba_pkg::t_cross o_n0,
    output tba_pkg::t_cross o_n1,
    output tba_pkg::t_cross o_n2
);

    tba_pkg::t_diff  r_e1x, r_e1y, r_e2x, r_e2y;
    tba_pkg::t_diff  r_a0x, r_a0y, r_a1x, r_a1y, r_a2x, r_a2y;
    tba_pkg::t_prod  r_pd_a, r_pd_b, r_p0_a, r_p0_b, r_p1_a, r_p1_b, r_p2_a, r_p2_b;
    tba_pkg::t_cross r_d, r_n0, r_n1, r_n2;

    // stage 1: edge vectors and point-relative vertices
    always_ff @(posedge i_clk) begin
        r_e1x <= tba_pkg::sub_ext(i_x1, i_x0);
        r_e1y <= tba_pkg::sub_ext(i_y1, i_y0);
        r_e2x <= tba_pkg::sub_ext(i_x2, i_x0);
        r_e2y <= tba_pkg::sub_ext(i_y2, i_y0);
        r_a0x <= tba_pkg::sub_ext(i_x0, i_px);
        r_a0y <= tba_pkg::sub_ext(i_y0, i_py);
        r_a1x <= tba_pkg::sub_ext(i_x1, i_px);
        r_a1y <= tba_pkg::sub_ext(i_y1, i_py);
        r_a2x <= tba_pkg::sub_ext(i_x2, i_px);
        r_a2y <= tba_pkg::sub_ext(i_y2, i_py);
    end

    // stage 2: products
    always_ff @(posedge i_clk) begin
        r_pd_a <= r_e1x * r_e2y;
        r_pd_b <= r_e2x * r_e1y;
        r_p0_a <= r_a1x * r_a2y;
        r_p0_b <= r_a2x * r_a1y;
        r_p1_a <= r_a2x * r_a0y;
        r_p1_b <= r_a0x * r_a2y;
        r_p2_a <= r_a0x * r_a1y;
        r_p2_b <= r_a1x * r_a0y;
    end

    // stage 3: cross products
    always_ff @(posedge i_clk) begin
        r_d  <= tba_pkg::t_cross'(r_pd_a) - tba_pkg::t_cross'(r_pd_b);
        r_n0 <= tba_pkg::t_cross'(r_p0_a) - tba_pkg::t_cross'(r_p0_b);
        r_n1 <= tba_pkg::t_cross'(r_p1_a) - tba_pkg::t_cross'(r_p1_b);
        r_n2 <= tba_pkg::t_cross'(r_p2_a) - tba_pkg::t_cross'(r_p2_b);
    end

    assign o_d  = r_d;
    assign o_n0 = r_n0;
    assign o_n1 = r_n1;
    assign o_n2 = r_n2;

endmodule

[design/tba_div_pipe.sv]
module tba_div_pipe (
    input  logic          i_clk,
    input  tba_pkg::t_mag  i_num,
    input  tba_pkg::t_mag  i_den,
    output tba_pkg::t_wmag o_mag
);

    logic [tba_pkg::REM_W-1:0] r_rem [0:tba_pkg::Q_W];
    tba_pkg::t_mag             r_den [0:tba_pkg::Q_W];
    logic [tba_pkg::Q_W-1:0]   r_q   [0:tba_pkg::Q_W];
    logic                      r_ovf [0:tba_pkg::Q_W];
    tba_pkg::t_wmag            r_mag;

    logic [tba_pkg::REM_W-1:0] num_sh;
    logic [tba_pkg::REM_W-1:0] den_top;
    logic [tba_pkg::Q_W:0]     n_round;

    assign num_sh  = tba_pkg::REM_W'(i_num) << (tba_pkg::WFRAC + 1);
    assign den_top = tba_pkg::REM_W'(i_den) << tba_pkg::Q_W;

    // quotient would not fit in Q_W bits: saturates anyway
    always_ff @(posedge i_clk) begin
        r_rem[0] <= num_sh;
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_ovf[0] <= (num_sh >= den_top);
    end

    // one restoring step per stage, MSB first
    for (genvar s = 0; s < tba_pkg::Q_W; s++) begin : g_step
        logic [tba_pkg::REM_W-1:0] sh;
        logic                      ge;
        assign sh = tba_pkg::REM_W'(r_den[s]) << (tba_pkg::Q_W - 1 - s);
        assign ge = (r_rem[s] >= sh);
        always_ff @(posedge i_clk) begin
            r_rem[s+1] <= ge ? (r_rem[s] - sh) : r_rem[s];
            r_q[s+1]   <= ge ? (r_q[s] | (tba_pkg::Q_W'(1) << (tba_pkg::Q_W - 1 - s)))
                             : r_q[s];
            r_den[s+1] <= r_den[s];
            r_ovf[s+1] <= r_ovf[s];
        end
    end

    // round half up on the extra bit, then cap
    assign n_round = ({1'b0, r_q[tba_pkg::Q_W]} + (tba_pkg::Q_W + 1)'(1)) >> 1;

    always_ff @(posedge i_clk) begin
        if (r_ovf[tba_pkg::Q_W] || (n_round > (tba_pkg::Q_W + 1)'(tba_pkg::W_CAP))) begin
            r_mag <= tba_pkg::W_CAP;
        end else begin
            r_mag <= n_round[tba_pkg::WEIGHT_W-1:0];
        end
    end

    assign o_mag = r_mag;

endmodule

[bench/tba_checker.sv]
module tba_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [tba_pkg::INDEX_W-1:0]         i_element_index,
    input  logic signed [tba_pkg::COORD_W-1:0]  i_vert0_x,
    input  logic signed [tba_pkg::COORD_W-1:0]  i_vert0_y,
    input  logic signed [tba_pkg::COORD_W-1:0]  i_vert1_x,
    input  logic signed [tba_pkg::COORD_W-1:0]  i_vert1_y,
    input  logic signed [tba_pkg::COORD_W-1:0]  i_vert2_x,
    input  logic signed [tba_pkg::COORD_W-1:0]  i_vert2_y,
    input  logic signed [tba_pkg::COORD_W-1:0]  i_point_x,
    input  logic signed [tba_pkg::COORD_W-1:0]  i_point_y,
    input  logic                                i_cfg_valid,
    input  logic                                o_cfg_ready,
    input  logic [tba_pkg::INDEX_W-1:0]         i_cfg_data,
    input  logic                                o_strobe,
    input  logic [tba_pkg::INDEX_W-1:0]         o_index_tag,
    input  logic signed [tba_pkg::WEIGHT_W-1:0] o_weight0,
    input  logic signed [tba_pkg::WEIGHT_W-1:0] o_weight1,
    input  logic signed [tba_pkg::WEIGHT_W-1:0] o_weight2,
    input  logic                                o_inside_res,
    input  logic [tba_pkg::MAG_W-1:0]           o_area,
    input  logic                                o_degenerate,
    input  logic                                o_index_error,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [tba_pkg::INDEX_W-1:0]         tag;
        logic signed [tba_pkg::WEIGHT_W-1:0] w0;
        logic signed [tba_pkg::WEIGHT_W-1:0] w1;
        logic signed [tba_pkg::WEIGHT_W-1:0] w2;
        logic                                in_tri;
        logic [tba_pkg::MAG_W-1:0]           area;
        logic                                deg;
        logic                                idx_err;
    } t_bary;

    localparam longint WCAP = longint'(1) << (tba_pkg::WEIGHT_W - 1);

    t_bary                         bary_q[$];
    logic [tba_pkg::INDEX_W-1:0]   elem_count;

    // n/d in Q4.16, rounded half away from zero, saturated
    function automatic logic signed [tba_pkg::WEIGHT_W-1:0] bary_weight(longint n,
                                                                        longint d);
        longint un, ud, q, mag;
        bit     neg;
        neg = (n < 0) != (d < 0);
        un  = (n < 0) ? -n : n;
        ud  = (d < 0) ? -d : d;
        q   = (un <<< (tba_pkg::WFRAC + 1)) / ud;
        mag = (q + 1) >>> 1;
        if (mag > WCAP) mag = WCAP;
        if (neg) return tba_pkg::WEIGHT_W'(-mag);
        if (mag > WCAP - 1) mag = WCAP - 1;
        return tba_pkg::WEIGHT_W'(mag);
    endfunction

    function automatic t_bary predict_bary(logic [tba_pkg::INDEX_W-1:0] idx,
                                           logic [tba_pkg::INDEX_W-1:0] cnt,
                                           longint x0, longint y0, longint x1, longint y1,
                                           longint x2, longint y2, longint px, longint py);
        t_bary  r;
        longint d, n0, n1, n2;
        r = '0;
        r.tag = idx;
        if (idx >= cnt) begin
            r.idx_err = 1'b1;
            return r;
        end
        d = (x1 - x0) * (y2 - y0) - (x2 - x0) * (y1 - y0);
        if (d == 0) begin
            r.deg = 1'b1;
            return r;
        end
        n0 = (x1 - px) * (y2 - py) - (x2 - px) * (y1 - py);
        n1 = (x2 - px) * (y0 - py) - (x0 - px) * (y2 - py);
        n2 = (x0 - px) * (y1 - py) - (x1 - px) * (y0 - py);
        r.w0 = bary_weight(n0, d);
        r.w1 = bary_weight(n1, d);
        r.w2 = bary_weight(n2, d);
        if (d > 0) r.in_tri = (n0 >= 0) && (n1 >= 0) && (n2 >= 0);
        else       r.in_tri = (n0 <= 0) && (n1 <= 0) && (n2 <= 0);
        r.area = tba_pkg::MAG_W'((d < 0) ? -d : d);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_bary exp_r, got;
        if (!i_rst_n) begin
            elem_count = '0;
            o_fail_count = 0;
            bary_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                elem_count = i_cfg_data;
            if (start && !busy)
                bary_q.insert(bary_q.size(), predict_bary(i_element_index, elem_count,
                    i_vert0_x, i_vert0_y, i_vert1_x, i_vert1_y,
                    i_vert2_x, i_vert2_y, i_point_x, i_point_y));
            if (o_strobe) begin
                got = '{o_index_tag, o_weight0, o_weight1, o_weight2, o_inside_res,
                        o_area, o_degenerate, o_index_error};
                if (bary_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result word, tag %0d", o_index_tag);
                end else begin
                    exp_r = bary_q.pop_front();
                    if (got !== exp_r) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"mismatch tag %0d/%0d w %0d %0d %0d / %0d %0d %0d ",
                                      "in %0b/%0b area %0d/%0d deg %0b/%0b err %0b/%0b"},
                                exp_r.tag, got.tag, exp_r.w0, exp_r.w1, exp_r.w2,
                                got.w0, got.w1, got.w2, exp_r.in_tri, got.in_tri,
                                exp_r.area, got.area, exp_r.deg, got.deg,
                                exp_r.idx_err, got.idx_err);
                    end
                end
            end
        end
        o_pending = bary_q.size();
    end

endmodule

[bench/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 30;
    localparam int CYC_LIMIT = 400000;

    logic i_clk, i_rst_n, start, busy;
    logic [tba_pkg::INDEX_W-1:0] i_element_index;
    tba_pkg::t_coord i_vert0_x, i_vert0_y, i_vert1_x, i_vert1_y, i_vert2_x, i_vert2_y;
    tba_pkg::t_coord i_point_x, i_point_y;
    logic i_cfg_valid, o_cfg_ready;
    logic [tba_pkg::INDEX_W-1:0] i_cfg_data;
    logic o_strobe, o_inside_res, o_degenerate, o_index_error;
    logic [tba_pkg::INDEX_W-1:0] o_index_tag;
    logic signed [tba_pkg::WEIGHT_W-1:0] o_weight0, o_weight1, o_weight2;
    logic [tba_pkg::MAG_W-1:0] o_area;
    int fail_count, pending;
    int cycles = 0;
    bit idle_en;
    logic [tba_pkg::INDEX_W-1:0] cur_count;

    triangle_barycentric_area_core u_top (.*);

    tba_checker u_chk (
        .*,
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_word(logic [tba_pkg::INDEX_W-1:0] idx,
                             tba_pkg::t_coord x0, tba_pkg::t_coord y0,
                             tba_pkg::t_coord x1, tba_pkg::t_coord y1,
                             tba_pkg::t_coord x2, tba_pkg::t_coord y2,
                             tba_pkg::t_coord px, tba_pkg::t_coord py);
        if (idle_en && $urandom_range(99) < 7) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_element_index <= idx;
        i_vert0_x <= x0; i_vert0_y <= y0;
        i_vert1_x <= x1; i_vert1_y <= y1;
        i_vert2_x <= x2; i_vert2_y <= y2;
        i_point_x <= px; i_point_y <= py;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_count(logic [tba_pkg::INDEX_W-1:0] val);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_count = val;
    endtask

    function automatic tba_pkg::t_coord near(tba_pkg::t_coord base, int span);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return tba_pkg::t_coord'(v);
    endfunction

    function automatic logic [tba_pkg::INDEX_W-1:0] pick_index();
        if (cur_count != 0 && $urandom_range(99) < 85)
            return tba_pkg::INDEX_W'($urandom_range(int'(cur_count) - 1));
        return tba_pkg::INDEX_W'($urandom);
    endfunction

    task automatic random_word();
        tba_pkg::t_coord x0, y0, x1, y1, x2, y2, px, py, dx, dy;
        int mode, k;
        mode = $urandom_range(99);
        x0 = tba_pkg::t_coord'($urandom); y0 = tba_pkg::t_coord'($urandom);
        x1 = tba_pkg::t_coord'($urandom); y1 = tba_pkg::t_coord'($urandom);
        x2 = tba_pkg::t_coord'($urandom); y2 = tba_pkg::t_coord'($urandom);
        px = tba_pkg::t_coord'($urandom); py = tba_pkg::t_coord'($urandom);
        if (mode < 60) begin
            // compact triangle, point around it
            x0 = near(16'sd0, 16000); y0 = near(16'sd0, 16000);
            x1 = near(x0, 400); y1 = near(y0, 400);
            x2 = near(x0, 400); y2 = near(y0, 400);
            px = near(x0, 500); py = near(y0, 500);
        end else if (mode < 85 && mode >= 75) begin
            // collinear vertices
            x0 = near(16'sd0, 8000); y0 = near(16'sd0, 8000);
            dx = near(16'sd0, 300); dy = near(16'sd0, 300);
            k  = $urandom_range(0, 6) - 3;
            x1 = x0 + dx; y1 = y0 + dy;
            x2 = x0 + tba_pkg::t_coord'(k) * dx; y2 = y0 + tba_pkg::t_coord'(k) * dy;
        end else if (mode < 92 && mode >= 85) begin
            // point on a vertex
            x0 = near(16'sd0, 16000); y0 = near(16'sd0, 16000);
            x1 = near(x0, 2000); y1 = near(y0, 2000);
            x2 = near(x0, 2000); y2 = near(y0, 2000);
            px = (mode & 1) ? x1 : x2; py = (mode & 1) ? y1 : y2;
        end else if (mode >= 92) begin
            // tiny triangle, far point: saturated weights
            x0 = near(16'sd0, 1000); y0 = near(16'sd0, 1000);
            x1 = x0 + 16'sd1; y1 = y0;
            x2 = x0; y2 = y0 + tba_pkg::t_coord'($urandom_range(1, 2));
        end
        send_word(pick_index(), x0, y0, x1, y1, x2, y2, px, py);
    endtask

    localparam tba_pkg::t_coord CMIN = -16'sd32768;
    localparam tba_pkg::t_coord CMAX = 16'sd32767;

    initial begin
        idle_en = 1'b1;
        cur_count = '0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        i_element_index <= '0;
        {i_vert0_x, i_vert0_y, i_vert1_x, i_vert1_y} <= '0;
        {i_vert2_x, i_vert2_y, i_point_x, i_point_y} <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // count of zero after reset: every index is out of range
        send_word(16'd0, 0, 0, 16, 0, 0, 16, 4, 4);
        send_word(16'hFFFF, 0, 0, 16, 0, 0, 16, 4, 4);

        write_count(16'hFFFF);
        send_word(16'hFFFE, 0, 0, 16, 0, 0, 16, 4, 4);
        send_word(16'hFFFF, 0, 0, 16, 0, 0, 16, 4, 4);
        // widest triangles, both windings
        send_word(16'd1, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, 0, 0);
        send_word(16'd2, CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX);
        send_word(16'd3, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, CMIN, CMIN);
        // point on vertex, on edge, outside
        send_word(16'd4, 0, 0, 32, 0, 0, 32, 32, 0);
        send_word(16'd5, 0, 0, 32, 0, 0, 32, 16, 0);
        send_word(16'd6, 0, 0, 32, 0, 0, 32, 16, 16);
        send_word(16'd7, 0, 0, 32, 0, 0, 32, -1, 5);
        send_word(16'd8, 0, 0, 0, 32, 32, 0, 5, 5);
        // degenerate: coincident and collinear
        send_word(16'd9, 7, 7, 7, 7, 7, 7, 7, 7);
        send_word(16'd10, CMIN, CMIN, 0, 0, CMAX, CMAX, 1, 2);
        // saturation both ways
        send_word(16'd11, 0, 0, 1, 0, 0, 1, CMAX, CMAX);
        send_word(16'd12, 0, 0, 1, 0, 0, 1, CMIN, CMAX);
        // rounding tie region: thirds
        send_word(16'd13, 0, 0, 3, 0, 0, 3, 1, 1);
        send_word(16'd14, -3, 0, 0, -3, 0, 0, -1, -1);

        write_count(16'd1);
        send_word(16'd0, 0, 0, 16, 0, 0, 16, 2, 2);
        send_word(16'd1, 0, 0, 16, 0, 0, 16, 2, 2);

        for (int i = 0; i < 1250; i++) begin
            if (i == 250) write_count(16'hFFFF);
            if (i == 550) write_count(16'd1000);
            if (i == 800) write_count(tba_pkg::INDEX_W'($urandom));
            if (i == 1000) write_count(16'd0);
            if (i == 1050) write_count(16'd40000);
            idle_en = !(i >= 300 && i < 500);
            if (i == 650) drain_results();
            random_word();
        end

        drain_results();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[triangle_barycentric_area_core.f]
design/tba_pkg.sv
design/tba_cross.sv
design/tba_div_pipe.sv
design/triangle_barycentric_area_core.sv
bench/tba_checker.sv
bench/tb_top.sv
